// File: rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// Field widths and register indexes shared by the skyline atlas packer.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int DIM_W   = 13;   // glyph width / height, page edge
    localparam int POS_W   = 12;   // placement coordinates
    localparam int SFS_W   = 11;   // scaled_font_size register
    localparam int MRG_W   = 4;    // margin register
    localparam int CFG_W   = 11;   // widest register
    localparam int RECT_LIMIT = 4096;

    localparam logic [0:0] REG_SCALED_FONT_SIZE = 1'b0;
    localparam logic [0:0] REG_MARGIN           = 1'b1;

endpackage

// File: rtl/skyline_atlas_packer.sv
// ----------------------------------------------------------------------------
// skyline_atlas_packer
// Skyline bottom-left placement of glyph rectangles into square atlas pages.
// ----------------------------------------------------------------------------
// Flow: an oversize glyph goes from the check straight to the result; otherwise
//   each skyline column read while scanning a candidate page passes a read and
//   an evaluate state, then glyph columns are written (whole page on open).
// Throughput: one glyph at a time; the single-port skyline RAM sets the rate.
// Reset: page count cleared, registers to 16 and 1; skyline rows are cleared
//   by a write pass over the page edge when a page opens.
module skyline_atlas_packer
    import sap_pkg::*;
#(
    parameter int MAX_PAGES     = 4,
    parameter int MAX_PAGE_SIZE = 4096,
    parameter int MIN_PAGE_SIZE = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // glyph_width[12:0], glyph_height[25:13]
    input  logic              s_tuser,   // pixel_format
    output logic              m_tvalid,
    input  logic              m_tready,
    // placed[0], page_index[2:1], pos_x[14:3], pos_y[26:15], opened_page[27],
    // page_edge[40:28]
    output logic [47:0]       m_tdata
);

    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int DEPTH = MAX_PAGES * MAX_PAGE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = DIM_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PAGE, S_RD, S_EV, S_FIT, S_NEWPG, S_CLR, S_WR, S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [SFS_W-1:0]  sfs_reg;
    logic [MRG_W-1:0]  margin_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  page_reg, page_next;
    logic [EW-1:0]     mw_reg, mw_next, mh_reg, mh_next;
    logic              fmt_reg, fmt_next;
    logic [DIM_W-1:0]  j_reg, j_next, k_reg, k_next;
    logic [DIM_W-1:0]  top_reg, top_next, lmax_reg, lmax_next;
    logic [EW-1:0]     best_reg, best_next;
    logic [DIM_W-1:0]  bx_reg, bx_next;
    logic [DIM_W-1:0]  edge_reg, edge_next;
    logic              opened_reg, opened_next, placed_reg, placed_next;
    logic              m_valid_reg;
    logic [47:0]       m_data_reg;

    logic              page_fmt [MAX_PAGES];
    logic [DIM_W-1:0]  page_size [MAX_PAGES];
    logic              pg_wr;

    logic [DIM_W-1:0]  sky_mem [DEPTH];
    logic [DIM_W-1:0]  rd_data;
    logic              mem_we;
    logic [DIM_W-1:0]  mem_col;
    logic [DIM_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_addr;

    logic [PG_W-1:0]   pidx;
    logic [EW-1:0]     gw_ext, gh_ext, mrg2;
    logic [EW-1:0]     ev, evm1;
    logic [EW:0]       p2;
    logic [DIM_W-1:0]  ecap;
    logic [DIM_W-1:0]  jn;
    logic [DIM_W-1:0]  ntop, nl;
    logic              fin_load;
    logic [31:0]       pg32;

    assign pidx     = page_reg[PG_W-1:0];
    assign mem_addr = AW'(32'(pidx) * MAX_PAGE_SIZE) + AW'(mem_col);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pg32     = 32'(page_reg);
    assign fin_load = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    assign gw_ext = EW'(s_tdata[DIM_W-1:0]);
    assign gh_ext = EW'(s_tdata[2*DIM_W-1:DIM_W]);
    assign mrg2   = EW'({margin_reg, 1'b0});

    // New page edge: max(size*8,min,w,h), rounded up to pow2, cap MAX_PAGE_SIZE
    always_comb
    begin
        ev = EW'({sfs_reg, 3'b000});
        if (ev < EW'(MIN_PAGE_SIZE))
            ev = EW'(MIN_PAGE_SIZE);
        if (mw_reg > ev)
            ev = mw_reg;
        if (mh_reg > ev)
            ev = mh_reg;
        evm1 = ev - EW'(1);
        p2   = (EW+1)'(1);
        for (int i = 0; i < EW; i++)
        begin
            if (evm1[i])
                p2 = (EW+1)'(1) << (i + 1);
        end
        if (p2 > (EW+1)'(MAX_PAGE_SIZE))
            ecap = DIM_W'(MAX_PAGE_SIZE);
        else
            ecap = DIM_W'(p2);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        page_next   = page_reg;
        mw_next     = mw_reg;
        mh_next     = mh_reg;
        fmt_next    = fmt_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        top_next    = top_reg;
        lmax_next   = lmax_reg;
        best_next   = best_reg;
        bx_next     = bx_reg;
        edge_next   = edge_reg;
        opened_next = opened_reg;
        placed_next = placed_reg;
        pg_wr       = 1'b0;
        mem_we      = 1'b0;
        mem_col     = k_reg;
        mem_wdata   = '0;
        jn          = '0;
        ntop        = top_reg;
        nl          = lmax_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mw_next     = gw_ext + mrg2;
                    mh_next     = gh_ext + mrg2;
                    fmt_next    = s_tuser;
                    placed_next = 1'b0;
                    opened_next = 1'b0;
                    page_next   = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (mw_reg > EW'(RECT_LIMIT) || mh_reg > EW'(RECT_LIMIT))
                    state_next = S_FIN;
                else
                    state_next = S_PAGE;
            end
            S_PAGE:
            begin
                edge_next = page_size[pidx];
                if (page_reg >= cnt_reg)
                    state_next = S_NEWPG;
                else if (page_fmt[pidx] != fmt_reg
                         || mw_reg > EW'(page_size[pidx])
                         || mh_reg > EW'(page_size[pidx]))
                    page_next = page_reg + CNT_W'(1);
                else if (mw_reg == '0)
                begin
                    best_next  = '0;
                    bx_next    = '0;
                    state_next = S_FIT;
                end
                else
                begin
                    best_next  = '1;
                    j_next     = '0;
                    k_next     = '0;
                    top_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
                state_next = S_EV;
            S_EV:
            begin
                if (EW'(rd_data) >= best_reg)
                begin
                    // any window over this column cannot beat the best
                    jn = k_reg + DIM_W'(1);
                    if (EW'(jn) + mw_reg > EW'(edge_reg))
                        state_next = S_FIT;
                    else
                    begin
                        j_next     = jn;
                        k_next     = jn;
                        top_next   = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (rd_data >= top_reg)
                    begin
                        ntop = rd_data;
                        nl   = k_reg;
                    end
                    if (EW'(k_reg) + EW'(1) == EW'(j_reg) + mw_reg)
                    begin
                        best_next = EW'(ntop);
                        bx_next   = j_reg;
                        // restart past the last column holding the window max
                        jn = nl + DIM_W'(1);
                        if (ntop == '0 || EW'(jn) + mw_reg > EW'(edge_reg))
                            state_next = S_FIT;
                        else
                        begin
                            j_next     = jn;
                            k_next     = jn;
                            top_next   = '0;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        top_next   = ntop;
                        lmax_next  = nl;
                        k_next     = k_reg + DIM_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FIT:
            begin
                if (best_reg < EW'(edge_reg) && best_reg + mh_reg <= EW'(edge_reg))
                begin
                    placed_next = 1'b1;
                    k_next      = bx_reg;
                    state_next  = (mw_reg == '0) ? S_FIN : S_WR;
                end
                else
                begin
                    page_next  = page_reg + CNT_W'(1);
                    state_next = S_PAGE;
                end
            end
            S_NEWPG:
            begin
                if (cnt_reg >= CNT_W'(MAX_PAGES) || mw_reg > EW'(ecap)
                    || mh_reg > EW'(ecap))
                    state_next = S_FIN;
                else
                begin
                    pg_wr       = 1'b1;
                    page_next   = cnt_reg;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    edge_next   = ecap;
                    bx_next     = '0;
                    best_next   = '0;
                    k_next      = '0;
                    opened_next = 1'b1;
                    placed_next = 1'b1;
                    state_next  = S_CLR;
                end
            end
            S_CLR:
            begin
                // clear the new page and raise the glyph columns in one pass
                mem_we    = 1'b1;
                mem_wdata = (EW'(k_reg) < mw_reg) ? DIM_W'(mh_reg) : '0;
                k_next    = k_reg + DIM_W'(1);
                if (k_reg + DIM_W'(1) == edge_reg)
                    state_next = S_FIN;
            end
            S_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = DIM_W'(best_reg + mh_reg);
                k_next    = k_reg + DIM_W'(1);
                if (EW'(k_reg) + EW'(1) == EW'(bx_reg) + mw_reg)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            sfs_reg     <= SFS_W'(16);
            margin_reg  <= MRG_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_SCALED_FONT_SIZE: sfs_reg    <= cfg_data[SFS_W-1:0];
                    REG_MARGIN:           margin_reg <= cfg_data[MRG_W-1:0];
                    default:              ;
                endcase
            end
            if (fin_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        mw_reg     <= mw_next;
        mh_reg     <= mh_next;
        fmt_reg    <= fmt_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        top_reg    <= top_next;
        lmax_reg   <= lmax_next;
        best_reg   <= best_next;
        bx_reg     <= bx_next;
        edge_reg   <= edge_next;
        opened_reg <= opened_next;
        placed_reg <= placed_next;
        if (pg_wr)
        begin
            page_fmt[cnt_reg[PG_W-1:0]]  <= fmt_reg;
            page_size[cnt_reg[PG_W-1:0]] <= ecap;
        end
        if (fin_load)
        begin
            if (placed_reg)
                m_data_reg <= {7'd0, edge_reg, opened_reg, best_reg[POS_W-1:0],
                               bx_reg[POS_W-1:0], pg32[1:0], 1'b1};
            else
                m_data_reg <= '0;
        end
    end

    // skyline RAM, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sky_mem[mem_addr] <= mem_wdata;
        rd_data <= sky_mem[mem_addr];
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PAGES))
        else $error("page count above limit");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("page count jumped");
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == '0)
        else $error("rejected result carries data");
    a_open_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |-> m_tdata[26:3] == '0)
        else $error("opened page not placed at origin");
`endif

endmodule
